@@ rtl/jdk_pkg.sv @@
// ---------------------------------------------------------------------------
// jdk_pkg: shared types and constants for the joystick deadzone block.
// Register indexes, field widths and divider request/response structs.
// ---------------------------------------------------------------------------
package jdk_pkg;

   localparam int AXIS_W    = 16;
   localparam int DZ_W      = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 17;
   localparam int DIV_W     = 64;
   localparam int DIV_CNT_W = 7;

   localparam logic [CSR_IDX_W-1:0] REG_X_OFFSET    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_Y_OFFSET    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEADZONE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_SCALE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD   = 3'd4;

   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_PRESS   = 2'd1;
   localparam logic [1:0] ACT_RELEASE = 2'd2;

   localparam logic [15:0] RANGE_RESET = 16'd4096;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] num;
      logic [DIV_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic             busy;
      logic [DIV_W-1:0] quo;
   } div_rsp_type;

endpackage

@@ rtl/jdk_divider.sv @@
// ---------------------------------------------------------------------------
// jdk_divider: shared restoring divider, one quotient bit per cycle.
// Also used as a bit-pair square root unit when sqrt_mode is set.
// ---------------------------------------------------------------------------
module jdk_divider
   import jdk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        sqrt_mode,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     den_ff, den_in;
   logic [DIV_W-1:0]     num_ff, num_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 sq_ff, sq_in;
   logic [DIV_W:0]       trial;
   logic [DIV_W+1:0]     rem_sh;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sq_in   = sq_ff;
      done_in = 1'b0;
      rem_sh  = '0;
      trial   = '0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = '0;
         num_in  = req.num;
         den_in  = req.den;
         sq_in   = sqrt_mode;
         cnt_in  = sqrt_mode ? DIV_CNT_W'(DIV_W / 2) : DIV_CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sq_ff) begin
            // Digit-by-digit root: bring down two bits, trial 4q+1.
            rem_sh = {rem_ff, num_ff[DIV_W-1 -: 2]};
            trial  = rem_sh[DIV_W:0] - {1'b0, quo_ff[DIV_W-3:0], 2'b01};
            num_in = {num_ff[DIV_W-3:0], 2'b00};
            if (rem_sh[DIV_W+1] == 1'b0 && !trial[DIV_W]) begin
               rem_in = trial[DIV_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DIV_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b0};
            end
         end else begin
            rem_sh = {1'b0, rem_ff, num_ff[DIV_W-1]};
            trial  = rem_sh[DIV_W:0] - {1'b0, den_ff};
            num_in = {num_ff[DIV_W-2:0], 1'b0};
            if (!trial[DIV_W]) begin
               rem_in = trial[DIV_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[DIV_W-1:0];
               quo_in = {quo_ff[DIV_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      num_ff <= num_in;
      sq_ff  <= sq_in;
   end

   assign rsp.done = done_ff;
   assign rsp.busy = busy_ff;
   assign rsp.quo  = quo_ff;

endmodule

@@ rtl/joystick_deadzone_direction_keys.sv @@
// ---------------------------------------------------------------------------
// joystick_deadzone_direction_keys: radial deadzone stick conditioning.
// Offset, deadzone rescale, range divide, radius clamp, keys.
// ---------------------------------------------------------------------------
// Each changed sample runs up to five divides and one square root on the shared divider;
// a sample inside the deadzone skips the root and the later divides.
// A repeated sample is dropped in S_CHECK. One sample in flight at a time,
// so no new sample is accepted until the last result is registered.
// Reset (synchronous, active high) restores register defaults, clears the
// previous sample and all held keys, and empties the result register.
module joystick_deadzone_direction_keys
   import jdk_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // raw_x[15:0], raw_y[31:16]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,   // axis_x, axis_y, dir_right, dir_left,
                                             // dir_up, dir_down, action_x_neg,
                                             // action_x_pos, action_y_neg,
                                             // action_y_pos, zero fill
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_CHECK = 14'b00000000000010,
      S_DIVX  = 14'b00000000000100,
      S_DIVY  = 14'b00000000001000,
      S_SQX   = 14'b00000000010000,
      S_SQY   = 14'b00000000100000,
      S_ROOT  = 14'b00000001000000,
      S_DEN   = 14'b00000010000000,
      S_RS    = 14'b00000100000000,
      S_MX    = 14'b00001000000000,
      S_SX    = 14'b00010000000000,
      S_MY    = 14'b00100000000000,
      S_SY    = 14'b01000000000000,
      S_OUT   = 14'b10000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic             wait_ff, wait_in;

   logic signed [15:0] xoff_ff, yoff_ff;
   logic [16:0]        dz_ff;
   logic [15:0]        rng_ff, th_ff;
   logic [15:0]        prevx_ff, prevy_ff;
   logic [3:0]         held_ff, held_in;
   logic [15:0]        rx_ff, ry_ff;

   logic [40:0]        mx_ff, my_ff, mx_in, my_in;   // magnitudes, 2^-24 units
   logic               nx_ff, ny_ff, nx_in, ny_in;
   logic [63:0]        acc_ff, acc_in;               // r^2, the square root operand
   logic [63:0]        r_ff, r_in;
   logic [63:0]        f_ff, f_in;
   logic [63:0]        tmp_ff, tmp_in;
   logic               zero_ff, zero_in;

   logic               ovalid_ff, ovalid_in;
   logic [47:0]        odata_ff, odata_in;

   div_req_type        dreq;
   div_rsp_type        drsp;
   logic               dsqrt;

   jdk_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .sqrt_mode (dsqrt),
      .req       (dreq),
      .rsp       (drsp)
   );

   // Offset correction operands for one axis.
   function automatic logic [63:0] oc_num(input logic [15:0] raw, input logic signed [15:0] off);
      logic signed [17:0] s;
      logic [17:0]        m;
      logic [17:0]        den;
      begin
         s   = 18'(signed'(raw)) + 18'(off);
         m   = s[17] ? 18'(-s) : 18'(s);
         den = (!s[17] && s != 0) ? 18'(18'sd32768 + 18'(off)) : 18'(18'sd32768 - 18'(off));
         oc_num = {m, 24'd0} + 64'(den[17:1]);
      end
   endfunction

   function automatic logic [63:0] oc_den(input logic [15:0] raw, input logic signed [15:0] off);
      logic signed [17:0] s;
      begin
         s = 18'(signed'(raw)) + 18'(off);
         oc_den = (!s[17] && s != 0) ? 64'(18'sd32768 + 18'(off)) : 64'(18'sd32768 - 18'(off));
      end
   endfunction

   function automatic logic oc_div(input logic signed [15:0] off);
      oc_div = (off > -16'sd24576) && (off < 16'sd24576);
   endfunction

   function automatic logic [40:0] oc_shift(input logic [15:0] raw, input logic signed [15:0] off);
      logic signed [17:0] s;
      begin
         s = 18'(signed'(raw)) + 18'(off);
         oc_shift = s[17] ? 41'({18'(-s), 9'd0}) : 41'({18'(s), 9'd0});
      end
   endfunction

   function automatic logic oc_neg(input logic [15:0] raw, input logic signed [15:0] off);
      logic signed [17:0] s;
      begin
         s = 18'(signed'(raw)) + 18'(off);
         oc_neg = s[17];
      end
   endfunction

   logic [15:0] ax_mag, ay_mag;
   logic [40:0] sx_m, sy_m;
   logic [63:0] prodx, prody;
   logic [24:0] th24;

   always_comb begin
      prodx  = 64'(mx_ff[24:0]) * 64'(15'd32767) + 64'h800000;
      prody  = 64'(my_ff[24:0]) * 64'(15'd32767) + 64'h800000;
      ax_mag = prodx[39:24];
      ay_mag = prody[39:24];
      sx_m   = mx_ff;
      sy_m   = my_ff;
      th24   = {1'b0, th_ff, 8'd0};
   end

   always_comb begin
      state_in  = state_ff;
      wait_in   = 1'b0;
      mx_in     = mx_ff;
      my_in     = my_ff;
      nx_in     = nx_ff;
      ny_in     = ny_ff;
      acc_in    = acc_ff;
      r_in      = r_ff;
      f_in      = f_ff;
      tmp_in    = tmp_ff;
      zero_in   = zero_ff;
      held_in   = held_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      odata_in  = odata_ff;
      dreq      = '0;
      dsqrt     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (rx_ff == prevx_ff && ry_ff == prevy_ff) begin
               state_in = S_IDLE;
            end else begin
               nx_in = oc_neg(rx_ff, xoff_ff);
               ny_in = oc_neg(ry_ff, yoff_ff);
               mx_in = oc_shift(rx_ff, xoff_ff);
               my_in = oc_shift(ry_ff, yoff_ff);
               dreq.start = oc_div(xoff_ff);
               dreq.num   = oc_num(rx_ff, xoff_ff);
               dreq.den   = oc_den(rx_ff, xoff_ff);
               wait_in    = 1'b1;
               state_in   = S_DIVX;
            end
         end
         S_DIVX: begin
            if (!wait_ff && !drsp.busy) begin
               if (oc_div(xoff_ff)) mx_in = drsp.quo[40:0];
               dreq.start = oc_div(yoff_ff);
               dreq.num   = oc_num(ry_ff, yoff_ff);
               dreq.den   = oc_den(ry_ff, yoff_ff);
               wait_in    = 1'b1;
               state_in   = S_DIVY;
            end
         end
         S_DIVY: begin
            if (!wait_ff && !drsp.busy) begin
               if (oc_div(yoff_ff)) my_in = drsp.quo[40:0];
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            // Magnitudes stay below 2^31, so a 32x32 product suffices.
            acc_in   = 64'(mx_ff[31:0]) * 64'(mx_ff[31:0]);
            state_in = S_SQY;
         end
         S_SQY: begin
            acc_in   = acc_ff + 64'(my_ff[31:0]) * 64'(my_ff[31:0]);
            tmp_in   = 64'({dz_ff, 8'd0}) * 64'({dz_ff, 8'd0});
            state_in = S_ROOT;
         end
         S_ROOT: begin
            zero_in = dz_ff[16] || (acc_ff <= tmp_ff);
            if (dz_ff[16] || (acc_ff <= tmp_ff)) begin
               mx_in    = '0;
               my_in    = '0;
               state_in = S_OUT;
            end else begin
               dreq.start = 1'b1;
               dsqrt      = 1'b1;
               dreq.num   = acc_ff;
               wait_in    = 1'b1;
               state_in   = S_DEN;
            end
         end
         S_DEN: begin
            if (!wait_ff && !drsp.busy) begin
               r_in     = drsp.quo;
               tmp_in   = 64'(17'(18'd65536 - 18'(dz_ff))) *
                          64'((rng_ff == 16'd0) ? 16'd1 : rng_ff);
               state_in = S_RS;
            end
         end
         S_RS: begin
            dreq.start = 1'b1;
            dreq.num   = (r_ff - 64'({dz_ff, 8'd0})) << 28;
            dreq.den   = tmp_ff;
            wait_in    = 1'b1;
            state_in   = S_MX;
         end
         S_MX: begin
            if (!wait_ff && !drsp.busy) begin
               f_in     = (drsp.quo > 64'h1000000) ? 64'h1000000 : drsp.quo;
               state_in = S_SX;
            end
         end
         S_SX: begin
            dreq.start = 1'b1;
            dreq.num   = 64'(mx_ff[31:0]) * 64'(f_ff[24:0]) + (r_ff >> 1);
            dreq.den   = r_ff;
            wait_in    = 1'b1;
            state_in   = S_MY;
         end
         S_MY: begin
            if (!wait_ff && !drsp.busy) begin
               mx_in      = drsp.quo[40:0];
               dreq.start = 1'b1;
               dreq.num   = 64'(my_ff[31:0]) * 64'(f_ff[24:0]) + (r_ff >> 1);
               dreq.den   = r_ff;
               wait_in    = 1'b1;
               state_in   = S_SY;
            end
         end
         S_SY: begin
            if (!wait_ff && !drsp.busy) begin
               my_in    = drsp.quo[40:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!ovalid_ff || rsp_tready) begin
               logic [15:0] axv, ayv;
               logic [1:0]  a0, a1, a2, a3;
               logic        xnz, ynz, xp, yp;
               logic        bx, by;
               axv = nx_ff ? 16'(-ax_mag) : ax_mag;
               ayv = ny_ff ? 16'(-ay_mag) : ay_mag;
               xnz = (ax_mag != 0);
               ynz = (ay_mag != 0);
               xp  = xnz && !nx_ff;
               yp  = ynz && !ny_ff;
               a0 = ACT_NONE; a1 = ACT_NONE; a2 = ACT_NONE; a3 = ACT_NONE;
               bx = xp;
               by = yp;
               // Sign-side key: release when zero, press when newly held.
               if (!bx) begin
                  if (!xnz) a0 = ACT_RELEASE;
                  else if (!held_ff[0]) a0 = ACT_PRESS;
                  if (held_ff[1]) a1 = ACT_RELEASE;
               end else begin
                  if (!held_ff[1]) a1 = ACT_PRESS;
                  if (held_ff[0]) a0 = ACT_RELEASE;
               end
               if (!by) begin
                  if (!ynz) a2 = ACT_RELEASE;
                  else if (!held_ff[2]) a2 = ACT_PRESS;
                  if (held_ff[3]) a3 = ACT_RELEASE;
               end else begin
                  if (!held_ff[3]) a3 = ACT_PRESS;
                  if (held_ff[2]) a2 = ACT_RELEASE;
               end
               held_in = {by, !by && ynz, bx, !bx && xnz};
               odata_in = {4'd0, a3, a2, a1, a0,
                           ny_ff && (sy_m > 41'(th24)),
                           !ny_ff && (sy_m > 41'(th24)),
                           nx_ff && (sx_m > 41'(th24)),
                           !nx_ff && (sx_m > 41'(th24)),
                           ayv, axv};
               ovalid_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         wait_ff   <= 1'b0;
         xoff_ff   <= '0;
         yoff_ff   <= '0;
         dz_ff     <= '0;
         rng_ff    <= RANGE_RESET;
         th_ff     <= '0;
         prevx_ff  <= '0;
         prevy_ff  <= '0;
         held_ff   <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wait_ff   <= wait_in;
         held_ff   <= held_in;
         ovalid_ff <= ovalid_in;
         if (state_ff == S_CHECK) begin
            prevx_ff <= rx_ff;
            prevy_ff <= ry_ff;
         end
         if (csr_we) begin
            case (csr_index)
               REG_X_OFFSET:    xoff_ff <= csr_wdata[15:0];
               REG_Y_OFFSET:    yoff_ff <= csr_wdata[15:0];
               REG_DEADZONE:    dz_ff   <= csr_wdata[16:0];
               REG_RANGE_SCALE: rng_ff  <= csr_wdata[15:0];
               REG_THRESHOLD:   th_ff   <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
      if (req_tvalid && req_tready) begin
         rx_ff <= req_tdata[15:0];
         ry_ff <= req_tdata[31:16];
      end
      mx_ff    <= mx_in;
      my_ff    <= my_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      acc_ff   <= acc_in;
      r_ff     <= r_in;
      f_ff     <= f_in;
      tmp_ff   <= tmp_in;
      zero_ff  <= zero_in;
      odata_ff <= odata_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;

`ifndef NO_ASSERTIONS
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready)
      else $error("ready while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped under stall");
   a_zero_axes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && zero_ff) |-> (mx_ff == 0 && my_ff == 0))
      else $error("deadzone output not zero");
`endif

endmodule
